>>> design/height_velocity_polygon_check_defines.svh
// Assertion macros shared by the checker of the height/velocity zone check.
// No dependencies; include by bare file name.
`ifndef HEIGHT_VELOCITY_POLYGON_CHECK_DEFINES_SVH
`define HEIGHT_VELOCITY_POLYGON_CHECK_DEFINES_SVH

// same-cycle implication
`define HVPC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HVPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/hvpc_pkg.sv
// Package for the height/velocity zone check: widths, codes, states, defaults.
// No dependencies.
package hvpc_pkg;

   localparam int COORD_W      = 24;          // Q15.8 coordinate
   localparam int DIFF_W       = COORD_W + 2; // exact difference of two coordinates
   localparam int PROD_W       = 2 * DIFF_W;
   localparam int FRAC_W       = 8;
   localparam int CELL_COORD_W = COORD_W - FRAC_W;
   localparam int MARK_W       = 2;

   localparam int DEF_POLYGONS       = 4;
   localparam int DEF_POINTS         = 16;
   localparam int DEF_HEIGHT_CELLS   = 64;
   localparam int DEF_VELOCITY_CELLS = 64;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_LOAD  = 2'd1,
      CMD_CHECK = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   localparam logic [MARK_W-1:0] MARK_NONE   = 2'd0;
   localparam logic [MARK_W-1:0] MARK_SAFE   = 2'd1;
   localparam logic [MARK_W-1:0] MARK_UNSAFE = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_LOAD,
      ST_ZONE,
      ST_LOAD_J,
      ST_LOAD_I,
      ST_MUL_L,
      ST_MUL_R,
      ST_COMPARE,
      ST_FINISH,
      ST_MREAD,
      ST_MREPLY
   } state_type;

endpackage

>>> design/hvpc_edge_mul.sv
// Shared signed multiplier of the edge test, product registered.
// Depends on hvpc_pkg.
module hvpc_edge_mul (
   input  logic                                 clock,
   input  logic signed [hvpc_pkg::DIFF_W-1:0]   op_a,
   input  logic signed [hvpc_pkg::DIFF_W-1:0]   op_b,
   output logic signed [hvpc_pkg::PROD_W-1:0]   product
);

   logic signed [hvpc_pkg::PROD_W-1:0] product_ff;
   logic signed [hvpc_pkg::PROD_W-1:0] product_in;

   assign product_in = op_a * op_b;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

>>> design/height_velocity_polygon_check.sv
// Height/velocity forbidden-zone check: top level with sequencer and memories.
// Depends on hvpc_pkg and hvpc_edge_mul.
//
// Usage:
//  - Command channel: a beat is taken when start is high and busy is low.
//    req_command selects clear, load vertex, check point or read grid mark.
//  - Result channel: rsp_strobe is high for exactly one cycle per command,
//    with rsp_safe and rsp_cell_mark valid in that cycle. There is no
//    backpressure; the receiver must take the beat when it appears.
//  - csr_wr_en/csr_wr_data write diagram_present; write only while idle.
//  - Steps from accept to strobe:
//      load  : ST_LOAD
//      read  : ST_MREAD, ST_MREPLY; check with no diagram goes the same way
//      check : ST_ZONE walks every zone with n >= 2, then ST_FINISH;
//              every edge takes four steps of the one shared multiplier
//              (one vertex read, two products, one compare).
//      clear : ST_CLEAR over all HEIGHT_CELLS*VELOCITY_CELLS, one mark cleared per cycle.
//  - busy stays high for the whole command; one command at a time.
//  - Reset: counts and diagram_present clear at once, then a clearing pass
//    over all HEIGHT_CELLS*VELOCITY_CELLS marks zeros the mark memory with busy
//    high and no result beat. Configuration writes are taken throughout.
module height_velocity_polygon_check #(
   parameter int POLYGONS       = hvpc_pkg::DEF_POLYGONS,
   parameter int POINTS         = hvpc_pkg::DEF_POINTS,
   parameter int HEIGHT_CELLS   = hvpc_pkg::DEF_HEIGHT_CELLS,
   parameter int VELOCITY_CELLS = hvpc_pkg::DEF_VELOCITY_CELLS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_command,
   input  logic [1:0]                          req_polygon_index,
   input  logic signed [hvpc_pkg::COORD_W-1:0] req_height,
   input  logic signed [hvpc_pkg::COORD_W-1:0] req_velocity,
   input  logic                                csr_wr_en,
   input  logic                                csr_wr_data,
   output logic                                rsp_strobe,
   output logic                                rsp_safe,
   output logic [hvpc_pkg::MARK_W-1:0]         rsp_cell_mark
);

   localparam int CW      = hvpc_pkg::COORD_W;
   localparam int CELLS   = HEIGHT_CELLS * VELOCITY_CELLS;
   localparam int CELL_AW = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int VDEPTH  = POLYGONS * POINTS;
   localparam int VERT_AW = $clog2(VDEPTH);
   localparam int CNT_W   = $clog2(POINTS + 1);
   localparam int ZI_W    = (POLYGONS > 1) ? $clog2(POLYGONS) : 1;
   localparam int ZC_W    = $clog2(POLYGONS + 1);

   // ---------------------------------------------------------------- state
   hvpc_pkg::state_type state_ff, state_in;
   hvpc_pkg::cmd_type   cmd_in;

   logic                      diag_ff, diag_in;
   logic [1:0]                zone_ff, zone_in;
   logic signed [CW-1:0]      h_ff, h_in, v_ff, v_in;       // raw vertex for load
   logic [CW-1:0]             th_ff, th_in, tv_ff, tv_in;   // absolute test point
   logic                      in_grid_ff, in_grid_in;
   logic [CELL_AW-1:0]        cell_ff, cell_in;
   logic [CNT_W-1:0]          counts_ff [POLYGONS];
   logic [CNT_W-1:0]          counts_in [POLYGONS];
   logic [CELL_AW-1:0]        clr_addr_ff, clr_addr_in;
   logic                      clr_reply_ff, clr_reply_in;
   logic [ZC_W-1:0]           zi_ff, zi_in;                 // zone walker
   logic [CNT_W-1:0]          pi_ff, pi_in;                 // edge index i
   logic signed [CW-1:0]      hi_ff, hi_in, vi_ff, vi_in;
   logic signed [CW-1:0]      hj_ff, hj_in, vj_ff, vj_in;
   logic                      odd_ff, odd_in;
   logic                      unsafe_ff, unsafe_in;
   logic                      noread_safe_ff, noread_safe_in; // safe bit for MREPLY
   logic signed [hvpc_pkg::PROD_W-1:0] lhs_ff, lhs_in;

   logic                      rsp_strobe_ff, rsp_strobe_in;
   logic                      rsp_safe_ff, rsp_safe_in;
   logic [hvpc_pkg::MARK_W-1:0] rsp_mark_ff, rsp_mark_in;

   // ------------------------------------------------------------- memories
   logic [2*CW-1:0]             vmem [VDEPTH];
   logic [2*CW-1:0]             vrd_ff;
   logic [VERT_AW-1:0]          v_rd_addr, v_wr_addr;
   logic                        v_we;

   logic [hvpc_pkg::MARK_W-1:0] mmem [CELLS];
   logic [hvpc_pkg::MARK_W-1:0] mrd_ff;
   logic [CELL_AW-1:0]          m_wr_addr;
   logic [hvpc_pkg::MARK_W-1:0] m_wr_data;
   logic                        m_we;

   always_ff @(posedge clock) begin
      if (v_we) begin
         vmem[v_wr_addr] <= {h_ff, v_ff};
      end
      vrd_ff <= vmem[v_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (m_we) begin
         mmem[m_wr_addr] <= m_wr_data;
      end
      mrd_ff <= mmem[cell_ff];
   end

   // ------------------------------------------------- accept-side decode
   logic [CW-1:0]                     h_abs, v_abs;
   logic [hvpc_pkg::CELL_COORD_W-1:0] hc, vc;

   always_comb begin
      h_abs = req_height[CW-1]   ? (CW'(0) - CW'(req_height))   : CW'(req_height);
      v_abs = req_velocity[CW-1] ? (CW'(0) - CW'(req_velocity)) : CW'(req_velocity);
      hc    = h_abs[CW-1:hvpc_pkg::FRAC_W];
      vc    = v_abs[CW-1:hvpc_pkg::FRAC_W];
   end

   // --------------------------------------------------------- edge datapath
   logic signed [hvpc_pkg::DIFF_W-1:0] th_x, tv_x, hi_x, vi_x, hj_x, vj_x;
   logic signed [hvpc_pkg::DIFF_W-1:0] op_a, op_b;
   logic signed [hvpc_pkg::PROD_W-1:0] product;
   logic                               straddle, d_pos, edge_cross;

   always_comb begin
      th_x = signed'({2'b00, th_ff});
      tv_x = signed'({2'b00, tv_ff});
      hi_x = signed'({{2{hi_ff[CW-1]}}, hi_ff});
      vi_x = signed'({{2{vi_ff[CW-1]}}, vi_ff});
      hj_x = signed'({{2{hj_ff[CW-1]}}, hj_ff});
      vj_x = signed'({{2{vj_ff[CW-1]}}, vj_ff});
      if (state_ff == hvpc_pkg::ST_MUL_L) begin
         op_a = tv_x - vi_x;     // (tv - vi) * d
         op_b = hj_x - hi_x;
      end else begin
         op_a = vj_x - vi_x;     // (vj - vi) * (th - hi)
         op_b = th_x - hi_x;
      end
      straddle   = (hi_x > th_x) != (hj_x > th_x);
      d_pos      = hj_ff > hi_ff;
      edge_cross = d_pos ? (lhs_ff < product) : (lhs_ff > product);
   end

   hvpc_edge_mul u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .product (product)
   );

   // ------------------------------------------------------------ sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= hvpc_pkg::ST_CLEAR;
         diag_ff       <= 1'b0;
         clr_addr_ff   <= '0;
         clr_reply_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         for (int k = 0; k < POLYGONS; k++) begin
            counts_ff[k] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         diag_ff       <= diag_in;
         clr_addr_ff   <= clr_addr_in;
         clr_reply_ff  <= clr_reply_in;
         rsp_strobe_ff <= rsp_strobe_in;
         counts_ff     <= counts_in;
      end
   end

   always_ff @(posedge clock) begin
      zone_ff        <= zone_in;
      h_ff           <= h_in;
      v_ff           <= v_in;
      th_ff          <= th_in;
      tv_ff          <= tv_in;
      in_grid_ff     <= in_grid_in;
      cell_ff        <= cell_in;
      zi_ff          <= zi_in;
      pi_ff          <= pi_in;
      hi_ff          <= hi_in;
      vi_ff          <= vi_in;
      hj_ff          <= hj_in;
      vj_ff          <= vj_in;
      odd_ff         <= odd_in;
      unsafe_ff      <= unsafe_in;
      noread_safe_ff <= noread_safe_in;
      lhs_ff         <= lhs_in;
      rsp_safe_ff    <= rsp_safe_in;
      rsp_mark_ff    <= rsp_mark_in;
   end

   logic [CNT_W-1:0]   zone_count;
   logic [VERT_AW-1:0] zone_base;

   always_comb begin
      state_in       = state_ff;
      diag_in        = csr_wr_en ? csr_wr_data : diag_ff;
      zone_in        = zone_ff;
      h_in           = h_ff;
      v_in           = v_ff;
      th_in          = th_ff;
      tv_in          = tv_ff;
      in_grid_in     = in_grid_ff;
      cell_in        = cell_ff;
      counts_in      = counts_ff;
      clr_addr_in    = clr_addr_ff;
      clr_reply_in   = clr_reply_ff;
      zi_in          = zi_ff;
      pi_in          = pi_ff;
      hi_in          = hi_ff;
      vi_in          = vi_ff;
      hj_in          = hj_ff;
      vj_in          = vj_ff;
      odd_in         = odd_ff;
      unsafe_in      = unsafe_ff;
      noread_safe_in = noread_safe_ff;
      lhs_in         = lhs_ff;
      rsp_strobe_in  = 1'b0;
      rsp_safe_in    = rsp_safe_ff;
      rsp_mark_in    = rsp_mark_ff;
      cmd_in         = hvpc_pkg::cmd_type'(req_command);

      zone_count = counts_ff[zi_ff[ZI_W-1:0]];
      zone_base  = VERT_AW'(32'(zi_ff) * POINTS);
      v_rd_addr  = VERT_AW'(32'(zone_base) + 32'(pi_ff));
      v_we       = 1'b0;
      v_wr_addr  = VERT_AW'(32'(zone_ff) * POINTS + 32'(counts_ff[ZI_W'(zone_ff)]));
      m_we       = 1'b0;
      m_wr_addr  = cell_ff;
      m_wr_data  = hvpc_pkg::MARK_NONE;

      unique case (state_ff)
         hvpc_pkg::ST_IDLE: begin
            if (start) begin
               zone_in    = req_polygon_index;
               h_in       = req_height;
               v_in       = req_velocity;
               th_in      = h_abs;
               tv_in      = v_abs;
               in_grid_in = (32'(hc) < HEIGHT_CELLS) && (32'(vc) < VELOCITY_CELLS);
               cell_in    = CELL_AW'(32'(vc) + 32'(hc) * VELOCITY_CELLS);
               zi_in      = '0;
               unsafe_in  = 1'b0;
               unique case (cmd_in)
                  hvpc_pkg::CMD_CLEAR: begin
                     for (int k = 0; k < POLYGONS; k++) begin
                        counts_in[k] = '0;
                     end
                     clr_addr_in  = '0;
                     clr_reply_in = 1'b1;
                     state_in     = hvpc_pkg::ST_CLEAR;
                  end
                  hvpc_pkg::CMD_LOAD: begin
                     state_in = hvpc_pkg::ST_LOAD;
                  end
                  hvpc_pkg::CMD_CHECK: begin
                     noread_safe_in = 1'b1;
                     state_in       = diag_ff ? hvpc_pkg::ST_ZONE : hvpc_pkg::ST_MREAD;
                  end
                  default: begin
                     noread_safe_in = 1'b0;
                     state_in       = hvpc_pkg::ST_MREAD;
                  end
               endcase
            end
         end
         hvpc_pkg::ST_CLEAR: begin
            m_we        = 1'b1;
            m_wr_addr   = clr_addr_ff;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (32'(clr_addr_ff) == CELLS - 1) begin
               state_in      = hvpc_pkg::ST_IDLE;
               clr_reply_in  = 1'b0;
               rsp_strobe_in = clr_reply_ff;
               rsp_safe_in   = 1'b0;
               rsp_mark_in   = hvpc_pkg::MARK_NONE;
            end
         end
         hvpc_pkg::ST_LOAD: begin
            if (32'(zone_ff) < POLYGONS) begin
               if (32'(counts_ff[ZI_W'(zone_ff)]) < POINTS) begin
                  v_we = 1'b1;
                  counts_in[ZI_W'(zone_ff)] = counts_ff[ZI_W'(zone_ff)] + 1'b1;
               end
            end
            state_in      = hvpc_pkg::ST_IDLE;
            rsp_strobe_in = 1'b1;
            rsp_safe_in   = 1'b0;
            rsp_mark_in   = hvpc_pkg::MARK_NONE;
         end
         hvpc_pkg::ST_ZONE: begin
            if (32'(zi_ff) == POLYGONS) begin
               state_in = hvpc_pkg::ST_FINISH;
            end else if (zone_count < CNT_W'(2)) begin
               zi_in = zi_ff + 1'b1;
            end else begin
               // prime j with the last vertex of the zone
               v_rd_addr = VERT_AW'(32'(zone_base) + 32'(zone_count) - 1);
               pi_in     = '0;
               odd_in    = 1'b0;
               state_in  = hvpc_pkg::ST_LOAD_J;
            end
         end
         hvpc_pkg::ST_LOAD_J: begin
            hj_in     = vrd_ff[2*CW-1:CW];
            vj_in     = vrd_ff[CW-1:0];
            v_rd_addr = zone_base;
            state_in  = hvpc_pkg::ST_LOAD_I;
         end
         hvpc_pkg::ST_LOAD_I: begin
            hi_in    = vrd_ff[2*CW-1:CW];
            vi_in    = vrd_ff[CW-1:0];
            state_in = hvpc_pkg::ST_MUL_L;
         end
         hvpc_pkg::ST_MUL_L: begin
            state_in = hvpc_pkg::ST_MUL_R;
         end
         hvpc_pkg::ST_MUL_R: begin
            lhs_in   = product;
            state_in = hvpc_pkg::ST_COMPARE;
         end
         hvpc_pkg::ST_COMPARE: begin
            hj_in = hi_ff;
            vj_in = vi_ff;
            if (straddle && edge_cross) begin
               odd_in = !odd_ff;
            end
            if (pi_ff == zone_count - 1'b1) begin
               if (odd_ff != (straddle && edge_cross)) begin
                  unsafe_in = 1'b1;
               end
               zi_in    = zi_ff + 1'b1;
               state_in = hvpc_pkg::ST_ZONE;
            end else begin
               pi_in     = pi_ff + 1'b1;
               v_rd_addr = VERT_AW'(32'(zone_base) + 32'(pi_ff) + 1);
               state_in  = hvpc_pkg::ST_LOAD_I;
            end
         end
         hvpc_pkg::ST_FINISH: begin
            m_we          = in_grid_ff;
            m_wr_data     = unsafe_ff ? hvpc_pkg::MARK_UNSAFE : hvpc_pkg::MARK_SAFE;
            state_in      = hvpc_pkg::ST_IDLE;
            rsp_strobe_in = 1'b1;
            rsp_safe_in   = !unsafe_ff;
            rsp_mark_in   = in_grid_ff ? m_wr_data : hvpc_pkg::MARK_NONE;
         end
         hvpc_pkg::ST_MREAD: begin
            state_in = hvpc_pkg::ST_MREPLY;   // mark memory read lands next cycle
         end
         hvpc_pkg::ST_MREPLY: begin
            state_in      = hvpc_pkg::ST_IDLE;
            rsp_strobe_in = 1'b1;
            rsp_safe_in   = noread_safe_ff;
            rsp_mark_in   = in_grid_ff ? mrd_ff : hvpc_pkg::MARK_NONE;
         end
         default: begin
            state_in = hvpc_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy          = (state_ff != hvpc_pkg::ST_IDLE);
   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_safe      = rsp_safe_ff;
   assign rsp_cell_mark = rsp_mark_ff;

endmodule

>>> design/hvpc_checker.sv
// Port-level checker for the height/velocity zone check, bound to the top.
// Depends on height_velocity_polygon_check_defines.svh.
`include "height_velocity_polygon_check_defines.svh"

module hvpc_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_strobe,
   input logic [1:0] rsp_cell_mark
);

   `HVPC_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "busy low after accept")
   `HVPC_ASSERT_NOW(a_beat_idle, clock, reset, rsp_strobe, !busy, "result beat while busy")
   `HVPC_ASSERT_NEXT(a_beat_single, clock, reset, rsp_strobe, !rsp_strobe, "two result beats")
   `HVPC_ASSERT_NOW(a_mark_code, clock, reset, rsp_strobe, rsp_cell_mark != 2'd3, "bad mark code")
   `HVPC_ASSERT_NOW(a_busy_cause, clock, reset, $rose(busy), $past(start), "busy without start")

endmodule

bind height_velocity_polygon_check hvpc_checker u_hvpc_checker (.*);
